/* design/lprl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprl_pkg: shared types for the longest prefix route lookup block
// Function and status codes, controller states, the stored route word and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int AddrW = 32;
  localparam int PortW = 6;
  localparam int FuncW = 2;
  localparam int StatW = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [StatW-1:0] {
    STAT_LOADED  = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_FOUND   = 3'd2,
    STAT_NOROUTE = 3'd3,
    STAT_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_POST
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
  } route_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // store route, or report table full
    logic clear;    // empty the table
    logic lookup;   // latch destination, reset best match and scan index
    logic issue;    // read the entry at the scan index and advance it
    logic post;     // move the finished result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic last_idx;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/lprl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprl_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lprl_ram #(
  parameter int WIDTH = 102,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/lprl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprl_ctrl: sequencer for the route lookup block
// Takes one item in idle, runs the table scan for lookups and posts the
// result when the output register is free.
// ----------------------------------------------------------------------------
module lprl_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [lprl_pkg::FuncW-1:0] func,
  input  lprl_pkg::dp_stat_t       dp_stat,
  output lprl_pkg::dp_cmd_t        dp_cmd
);

  lprl_pkg::state_t state, state_next;
  logic             accept;

  assign accept = in_valid && (state == lprl_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lprl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lprl_pkg::S_IDLE: begin
        if (accept) begin
          case (func)
            lprl_pkg::FUNC_LOAD,
            lprl_pkg::FUNC_CLEAR:  state_next = lprl_pkg::S_POST;
            lprl_pkg::FUNC_LOOKUP: begin
              state_next = dp_stat.count_zero ? lprl_pkg::S_POST : lprl_pkg::S_SCAN;
            end
            default: state_next = lprl_pkg::S_IDLE;
          endcase
        end
      end
      lprl_pkg::S_SCAN: begin
        if (dp_stat.last_idx) begin
          state_next = lprl_pkg::S_FLUSH;
        end
      end
      lprl_pkg::S_FLUSH: state_next = lprl_pkg::S_POST;
      lprl_pkg::S_POST: begin
        if (dp_stat.out_free) begin
          state_next = lprl_pkg::S_IDLE;
        end
      end
      default: state_next = lprl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd   = '0;
    in_stall = (state != lprl_pkg::S_IDLE);
    case (state)
      lprl_pkg::S_IDLE: begin
        if (accept) begin
          case (func)
            lprl_pkg::FUNC_LOAD:   dp_cmd.load   = 1'b1;
            lprl_pkg::FUNC_CLEAR:  dp_cmd.clear  = 1'b1;
            lprl_pkg::FUNC_LOOKUP: dp_cmd.lookup = 1'b1;
            default: ;
          endcase
        end
      end
      lprl_pkg::S_SCAN:  dp_cmd.issue = 1'b1;
      lprl_pkg::S_FLUSH: ;
      lprl_pkg::S_POST:  dp_cmd.post = dp_stat.out_free;
      default: ;
    endcase
  end

endmodule

/* design/lprl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprl_dp: datapath for the route lookup block
// Route count, scan index, one match compare per cycle, best match
// registers and the output register.
// ----------------------------------------------------------------------------
module lprl_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lprl_pkg::dp_cmd_t             dp_cmd,
  output lprl_pkg::dp_stat_t            dp_stat,
  input  logic [lprl_pkg::AddrW-1:0]    dest_addr,
  input  logic [lprl_pkg::AddrW-1:0]    route_prefix_in,
  input  logic [lprl_pkg::AddrW-1:0]    route_mask_in,
  input  logic [lprl_pkg::AddrW-1:0]    next_hop_in,
  input  logic [lprl_pkg::PortW-1:0]    port_in,
  output logic                          ram_wr_en,
  output logic [$clog2(ENTRIES)-1:0]    ram_wr_addr,
  output lprl_pkg::route_t              ram_wr_data,
  output logic                          ram_rd_en,
  output logic [$clog2(ENTRIES)-1:0]    ram_rd_addr,
  input  lprl_pkg::route_t              ram_rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lprl_pkg::StatW-1:0]    status,
  output logic [lprl_pkg::AddrW-1:0]    next_hop_out,
  output logic [lprl_pkg::PortW-1:0]    port_out,
  output logic [lprl_pkg::AddrW-1:0]    mask_out
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(ENTRIES);

  logic [CW-1:0]              count;
  logic [AW-1:0]              idx;
  logic                       full;
  logic                       rd_pending;
  logic                       found;
  logic                       op_lookup;
  lprl_pkg::status_t          res_status;
  logic [lprl_pkg::AddrW-1:0] dest;
  logic [lprl_pkg::AddrW-1:0] best_mask;
  logic [lprl_pkg::AddrW-1:0] best_hop;
  logic [lprl_pkg::PortW-1:0] best_port;
  logic                       match;
  logic                       take;

  assign full = (count == Full);

  // status to controller
  assign dp_stat.count_zero = (count == '0);
  assign dp_stat.last_idx   = (CW'(idx) == count - CW'(1));
  assign dp_stat.out_free   = !out_valid || !out_stall;

  // table write at the fill count, scan read at the index
  assign ram_wr_en   = dp_cmd.load && !full;
  assign ram_wr_addr = count[AW-1:0];
  assign ram_wr_data = '{prefix: route_prefix_in, mask: route_mask_in,
                         gateway: next_hop_in, port: port_in};
  assign ram_rd_en   = dp_cmd.issue;
  assign ram_rd_addr = idx;

  // compare the entry read last cycle; equal masks go to the later entry
  assign match = ((dest & ram_rd_data.mask) == ram_rd_data.prefix);
  assign take  = rd_pending && match && (!found || ram_rd_data.mask >= best_mask);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_pending <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= dp_cmd.issue;
      if (dp_cmd.clear) begin
        count <= '0;
      end else if (ram_wr_en) begin
        count <= count + CW'(1);
      end
      if (dp_cmd.lookup) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (dp_cmd.post) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item latch, scan index and best match
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_lookup  <= 1'b0;
      res_status <= full ? lprl_pkg::STAT_FULL : lprl_pkg::STAT_LOADED;
    end
    if (dp_cmd.clear) begin
      op_lookup  <= 1'b0;
      res_status <= lprl_pkg::STAT_CLEARED;
    end
    if (dp_cmd.lookup) begin
      op_lookup <= 1'b1;
      dest      <= dest_addr;
      idx       <= '0;
      best_mask <= '0;
      best_hop  <= '0;
      best_port <= '0;
    end
    if (dp_cmd.issue) begin
      idx <= idx + AW'(1);
    end
    if (take) begin
      best_mask <= ram_rd_data.mask;
      best_hop  <= ram_rd_data.gateway;
      best_port <= ram_rd_data.port;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (dp_cmd.post) begin
      if (op_lookup) begin
        status       <= found ? lprl_pkg::STAT_FOUND : lprl_pkg::STAT_NOROUTE;
        next_hop_out <= best_hop;
        port_out     <= best_port;
        mask_out     <= best_mask;
      end else begin
        status       <= res_status;
        next_hop_out <= '0;
        port_out     <= '0;
        mask_out     <= '0;
      end
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= Full)
    else $error("route count above table size");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load |-> (ram_wr_en == !full) && (ram_wr_addr == count[AW-1:0]))
    else $error("table write does not follow fill count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.issue |-> CW'(idx) < count)
    else $error("scan read beyond stored routes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.post |-> !(out_valid && out_stall))
    else $error("result posted over a stalled item");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lprl_pkg::STAT_FOUND) |->
      (next_hop_out == '0 && port_out == '0 && mask_out == '0))
    else $error("nonzero fields without a route");

endmodule

/* design/longest_prefix_route_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup: IPv4 route table with longest prefix match
//
// Input channel (in_valid / in_stall) carries one item: func selects load,
// lookup or clear; a load appends a route, a lookup matches dest_addr
// against every stored route, a clear empties the table. func 3 is dropped
// with no result. Output channel (out_valid / out_stall) returns one item
// per load, lookup or clear: status plus next hop, port and mask of the
// winning route (zero when there is none).
// From the accepting edge, a load or clear goes straight to posting; a lookup
// first scans the stored routes (skipped on an empty table), reading one
// table entry per cycle from the single read port of the route RAM, then
// compares the last entry read and posts. The next item is taken in the
// cycle after a result is posted. in_stall is high from acceptance until
// the result is posted.
// A stalled result holds in the output register; the block finishes the
// next item and waits for the register to free before posting it.
// Reset empties the table at once (fill count to zero) and drops any item.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] dest_addr,
  input  logic [31:0] route_prefix_in,
  input  logic [31:0] route_mask_in,
  input  logic [31:0] next_hop_in,
  input  logic [5:0]  port_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] next_hop_out,
  output logic [5:0]  port_out,
  output logic [31:0] mask_out
);

  localparam int AW = $clog2(ENTRIES);
  localparam int RW = $bits(lprl_pkg::route_t);

  lprl_pkg::dp_cmd_t  dp_cmd;
  lprl_pkg::dp_stat_t dp_stat;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  lprl_pkg::route_t   ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [RW-1:0]      ram_rd_data;

  lprl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  lprl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .dest_addr       (dest_addr),
    .route_prefix_in (route_prefix_in),
    .route_mask_in   (route_mask_in),
    .next_hop_in     (next_hop_in),
    .port_in         (port_in),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (lprl_pkg::route_t'(ram_rd_data)),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .next_hop_out    (next_hop_out),
    .port_out        (port_out),
    .mask_out        (mask_out)
  );

  lprl_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (RW'(ram_wr_data)),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for longest_prefix_route_lookup
// Walks a short table of directed items, some with hand-written answers, then
// random episodes that build nested and tied routes over a few networks and
// look them up. Other answers are checked against an in-bench route table.
// Both sides idle at random; the receiver also holds off once for a long time.
// ----------------------------------------------------------------------------
module tb;

  localparam int ROUTES       = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = ROUTES + 16;
  localparam logic [lprl_pkg::FuncW-1:0] FUNC_NONE = 2'd3;  // unused selector, no answer

  typedef struct {
    logic [lprl_pkg::FuncW-1:0] fn;
    logic [lprl_pkg::AddrW-1:0] dest;
    logic [lprl_pkg::AddrW-1:0] prefix;
    logic [lprl_pkg::AddrW-1:0] mask;
    logic [lprl_pkg::AddrW-1:0] hop;
    logic [lprl_pkg::PortW-1:0] port;
  } route_item_t;

  typedef struct {
    lprl_pkg::status_t          st;
    logic [lprl_pkg::AddrW-1:0] hop;
    logic [lprl_pkg::PortW-1:0] port;
    logic [lprl_pkg::AddrW-1:0] mask;
  } answer_t;

  typedef struct {
    route_item_t it;
    bit          known;
    answer_t     ans;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       func;
  logic [31:0]      dest_addr;
  logic [31:0]      route_prefix_in;
  logic [31:0]      route_mask_in;
  logic [31:0]      next_hop_in;
  logic [5:0]       port_in;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       status;
  logic [31:0]      next_hop_out;
  logic [5:0]       port_out;
  logic [31:0]      mask_out;

  // in-bench copy of the route table
  logic [lprl_pkg::AddrW-1:0] tbl_prefix [ROUTES];
  logic [lprl_pkg::AddrW-1:0] tbl_mask   [ROUTES];
  logic [lprl_pkg::AddrW-1:0] tbl_hop    [ROUTES];
  logic [lprl_pkg::PortW-1:0] tbl_port   [ROUTES];
  int                         tbl_count;

  logic [lprl_pkg::AddrW-1:0] net_pool [4];
  answer_t                    pending_answers [$];
  directed_row_t              directed_rows [$];
  int                         items_sent;
  int                         answers_seen;
  int                         mismatch_count;
  bit                         calm;
  bit                         mid_drained;

  longest_prefix_route_lookup #(.ENTRIES(ROUTES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .dest_addr(dest_addr), .route_prefix_in(route_prefix_in),
    .route_mask_in(route_mask_in), .next_hop_in(next_hop_in), .port_in(port_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .next_hop_out(next_hop_out), .port_out(port_out),
    .mask_out(mask_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Apply one item to the table copy; return 0 when the item gives no answer.
  function automatic bit route_answer(input route_item_t it, output answer_t ans);
    int best;
    bit hit;
    ans.st   = lprl_pkg::STAT_NOROUTE;
    ans.hop  = '0;
    ans.port = '0;
    ans.mask = '0;
    best     = 0;
    hit      = 1'b0;
    case (it.fn)
      lprl_pkg::FUNC_LOAD: begin
        if (tbl_count >= ROUTES) begin
          ans.st = lprl_pkg::STAT_FULL;
        end else begin
          tbl_prefix[tbl_count] = it.prefix;
          tbl_mask[tbl_count]   = it.mask;
          tbl_hop[tbl_count]    = it.hop;
          tbl_port[tbl_count]   = it.port;
          tbl_count++;
          ans.st = lprl_pkg::STAT_LOADED;
        end
      end
      lprl_pkg::FUNC_LOOKUP: begin
        // largest mask wins, later route wins a tie
        for (int i = 0; i < tbl_count; i++) begin
          if ((it.dest & tbl_mask[i]) == tbl_prefix[i] &&
              (!hit || tbl_mask[i] >= tbl_mask[best])) begin
            best = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          ans.st   = lprl_pkg::STAT_FOUND;
          ans.hop  = tbl_hop[best];
          ans.port = tbl_port[best];
          ans.mask = tbl_mask[best];
        end
      end
      lprl_pkg::FUNC_CLEAR: begin
        tbl_count = 0;
        ans.st    = lprl_pkg::STAT_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic add_row(input logic [1:0] fn, input logic [31:0] dest,
                         input logic [31:0] prefix, input logic [31:0] mask,
                         input logic [31:0] hop, input logic [5:0] port,
                         input bit known, input lprl_pkg::status_t st,
                         input logic [31:0] e_hop, input logic [5:0] e_port,
                         input logic [31:0] e_mask);
    directed_row_t row;
    row.it.fn     = fn;
    row.it.dest   = dest;
    row.it.prefix = prefix;
    row.it.mask   = mask;
    row.it.hop    = hop;
    row.it.port   = port;
    row.known     = known;
    row.ans.st    = st;
    row.ans.hop   = e_hop;
    row.ans.port  = e_port;
    row.ans.mask  = e_mask;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Drive one item from a falling edge, hold it until accepted, log its answer.
  task automatic offer(input route_item_t it, input bit known, input answer_t typed);
    answer_t want;
    in_valid        <= 1'b1;
    func            <= it.fn;
    dest_addr       <= it.dest;
    route_prefix_in <= it.prefix;
    route_mask_in   <= it.mask;
    next_hop_in     <= it.hop;
    port_in         <= it.port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (route_answer(it, want)) begin
      pending_answers.insert(pending_answers.size(), known ? typed : want);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected answer is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_answers.size() != 0);
  endtask

  // Random gap between items, one mid-run drain, and a stretch with no gaps.
  task automatic rest();
    calm = (items_sent >= 900 && items_sent < 1100);
    if (!mid_drained && items_sent >= 700) begin
      mid_drained = 1'b1;
      drain();
    end else if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic route_item_t rand_item(input logic [1:0] fn);
    route_item_t it;
    it.fn     = fn;
    it.dest   = $urandom;
    it.prefix = $urandom;
    it.mask   = $urandom;
    it.hop    = $urandom;
    it.port   = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // Routes mostly hang off a few networks so that they nest and tie.
  function automatic route_item_t rand_load();
    route_item_t it;
    int          len;
    int          r;
    int          k;
    it  = rand_item(lprl_pkg::FUNC_LOAD);
    r   = $urandom_range(0, 99);
    len = $urandom_range(8, 30);
    if (r < 5) len = 0;
    else if (r < 10) len = 32;
    it.mask   = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    it.prefix = net_pool[$urandom_range(0, 3)] & it.mask;
    r = $urandom_range(0, 99);
    if (r < 10 && tbl_count > 0) begin
      k         = $urandom_range(0, tbl_count - 1);
      it.prefix = tbl_prefix[k];
      it.mask   = tbl_mask[k];
    end else if (r < 16) begin
      it.mask   = $urandom;
      it.prefix = $urandom & it.mask;
    end else if (r < 20) begin
      it.prefix = $urandom;
    end
    return it;
  endfunction

  function automatic route_item_t rand_lookup();
    route_item_t it;
    int          r;
    int          k;
    it = rand_item(lprl_pkg::FUNC_LOOKUP);
    r  = $urandom_range(0, 99);
    if (r < 60) begin
      it.dest = net_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 32));
    end else if (r < 85 && tbl_count > 0) begin
      k       = $urandom_range(0, tbl_count - 1);
      it.dest = (tbl_prefix[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
    end
    return it;
  endfunction

  // Check each accepted answer against the oldest expectation.
  always @(posedge clk) begin : watch_answers
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: answer expected none actual status %0d", $time, status);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          mismatch_count++;
        end
        if (next_hop_out !== want.hop) begin
          $display("%0t: next_hop_out expected %h actual %h", $time, want.hop,
                   next_hop_out);
          mismatch_count++;
        end
        if (port_out !== want.port) begin
          $display("%0t: port_out expected %0d actual %0d", $time, want.port, port_out);
          mismatch_count++;
        end
        if (mask_out !== want.mask) begin
          $display("%0t: mask_out expected %h actual %h", $time, want.mask, mask_out);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off that backs the block up.
  initial begin : receiver
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held && answers_seen >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Sender: reset, directed table, random episodes, final drain.
  initial begin : sender
    route_item_t it;
    answer_t     none;
    int          n;
    int          r;
    rst             = 1'b1;
    in_valid        = 1'b0;
    func            = lprl_pkg::FUNC_LOAD;
    dest_addr       = '0;
    route_prefix_in = '0;
    route_mask_in   = '0;
    next_hop_in     = '0;
    port_in         = '0;
    tbl_count       = 0;
    items_sent      = 0;
    answers_seen    = 0;
    mismatch_count  = 0;
    calm            = 1'b0;
    mid_drained     = 1'b0;
    none.st         = lprl_pkg::STAT_LOADED;
    none.hop        = '0;
    none.port       = '0;
    none.mask       = '0;

    // fn, dest, prefix, mask, hop, port, known, answer
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_NOROUTE, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_CLEARED, 32'h0, 6'd0, 32'h0);
    // default route with all-ones hop and port
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 6'd63,
            1'b1, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_FOUND, 32'hFFFF_FFFF, 6'd63, 32'h0);
    // host route, all-ones prefix and mask
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_FOUND, 32'h0, 6'd0, 32'hFFFF_FFFF);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_FOUND, 32'hFFFF_FFFF, 6'd63, 32'h0);
    // two routes with equal masks: the later one wins
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A0A_0A01,
            6'd1, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A0A_0A02,
            6'd2, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    // prefix bits outside the mask: never matches
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h0A01_00FF, 32'hFFFF_0000, 32'h0000_0003,
            6'd5, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h0A01_00FF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    // longer prefix beats the /8
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001,
            6'd33, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h0A01_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    // unused selector: dropped, no answer
    add_row(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            6'd63, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    // non-contiguous mask
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'hF0F0_F0F0, 32'hF0F0_F0F0, 32'h1234_5678,
            6'd42, 1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'hFFF0_F0F0, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b0, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_CLEARED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_NOROUTE, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOAD, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_LOADED, 32'h0, 6'd0, 32'h0);
    add_row(lprl_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 6'd0,
            1'b1, lprl_pkg::STAT_NOROUTE, 32'h0, 6'd0, 32'h0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].it, directed_rows[i].known, directed_rows[i].ans);
      rest();
    end
    drain();

    // random episodes: optional clear, a run of mostly loads, then mostly lookups
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      foreach (net_pool[i]) net_pool[i] = $urandom;
      if ($urandom_range(0, 99) < 60) begin
        offer(rand_item(lprl_pkg::FUNC_CLEAR), 1'b0, none);
        rest();
      end
      n = ($urandom_range(0, 99) < 20) ? $urandom_range(55, 70) : $urandom_range(1, 16);
      repeat (n) begin
        it = ($urandom_range(0, 99) < 80) ? rand_load() : rand_lookup();
        offer(it, 1'b0, none);
        rest();
      end
      repeat ($urandom_range(5, 30)) begin
        r = $urandom_range(0, 99);
        if (r < 3) it = rand_item(FUNC_NONE);
        else if (r < 5) it = rand_item(lprl_pkg::FUNC_CLEAR);
        else it = rand_lookup();
        offer(it, 1'b0, none);
        rest();
      end
    end

    // wait out the last answers
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
